// ----- design/b64d_pkg.sv -----
package b64d_pkg;

	localparam int SEXTET_W = 6;
	localparam int GROUP_BYTES = 3;
	localparam int HELD_DEPTH = 3;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

	localparam logic [SEXTET_W-1:0] LOWER_BASE = 6'd26;
	localparam logic [SEXTET_W-1:0] DIGIT_BASE = 6'd52;
	localparam logic [SEXTET_W-1:0] PLUS_CODE = 6'd62;
	localparam logic [SEXTET_W-1:0] SLASH_CODE = 6'd63;

	typedef struct packed {
		logic [7:0] char_code;
		logic       final_char;
	} char_word_t;

	typedef struct packed {
		logic [7:0] byte_out;
		logic       byte_valid;
		logic       run_last;
		logic       stream_end;
	} result_word_t;

	typedef struct packed {
		logic [GROUP_BYTES-1:0][7:0] bytes;
		logic [1:0]                  nb;
		logic                        fin;
	} job_t;

	typedef struct packed {
		logic                hit;
		logic [SEXTET_W-1:0] val;
	} sextet_t;

	function automatic sextet_t sextet_of(input logic [7:0] ch);
		sextet_t r;
		r.hit = 1'b1;
		r.val = '0;
		if (ch inside {[8'h41:8'h5A]}) begin
			r.val = SEXTET_W'(ch - 8'h41);
		end else if (ch inside {[8'h61:8'h7A]}) begin
			r.val = SEXTET_W'(ch - 8'h61) + LOWER_BASE;
		end else if (ch inside {[8'h30:8'h39]}) begin
			r.val = SEXTET_W'(ch - 8'h30) + DIGIT_BASE;
		end else if (ch == 8'h2B) begin
			r.val = PLUS_CODE;
		end else if (ch == 8'h2F) begin
			r.val = SLASH_CODE;
		end else begin
			r.hit = 1'b0;
		end
		return r;
	endfunction

endpackage

// ----- design/base64_stream_decoder.sv -----
// A character that completes a group or is marked final is pushed into the job queue
// when accepted; the output stage registers each result word from the queue head.
// Throughput: one character per cycle; a group of four characters gives three
// results, one per cycle while result_ready is high, drained from a four-entry job
// queue by the output stage. The input stalls only when that queue is full.
// Reset: arst_n clears the held count, queue pointers and output valid at once.
module base64_stream_decoder (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   char_valid,
	output logic                   char_ready,
	input  b64d_pkg::char_word_t   char_word,
	output logic                   result_valid,
	input  logic                   result_ready,
	output b64d_pkg::result_word_t result_word
);
	import b64d_pkg::*;

	logic job_push;
	logic job_pop;
	job_t push_job;
	job_t head_job;
	logic queue_full;
	logic queue_empty;

	b64d_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.char_word  (char_word),
		.queue_full (queue_full),
		.job_push   (job_push),
		.job_word   (push_job)
	);

	b64d_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_push),
		.push_data (push_job),
		.pop       (job_pop),
		.pop_data  (head_job),
		.full      (queue_full),
		.empty     (queue_empty)
	);

	b64d_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_word     (head_job),
		.queue_empty  (queue_empty),
		.job_pop      (job_pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_word  (result_word)
	);

	a_empty_word: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_word.byte_valid |->
			result_word.run_last && result_word.stream_end && result_word.byte_out == 8'h00)
		else $error("empty result word is not a stream end");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_word.stream_end |-> result_word.run_last)
		else $error("stream end without run end");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		job_push |-> !queue_full)
		else $error("job queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> !queue_empty)
		else $error("job queue underflow");

endmodule

// ----- design/b64d_front.sv -----
module b64d_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 char_valid,
	output logic                 char_ready,
	input  b64d_pkg::char_word_t char_word,
	input  logic                 queue_full,
	output logic                 job_push,
	output b64d_pkg::job_t       job_word
);
	import b64d_pkg::*;

	logic [SEXTET_W-1:0] held_q [HELD_DEPTH];
	logic [1:0]          held_count_q;

	sextet_t             sx;
	logic                accept;
	logic                complete;
	logic                store;
	logic [1:0]          count_after;
	logic [SEXTET_W-1:0] h0, h1, h2;

	assign char_ready = !queue_full;
	assign accept = char_valid && char_ready;

	always_comb begin
		sx = sextet_of(char_word.char_code);
		complete = sx.hit && (held_count_q == 2'd3);
		store = sx.hit && !complete;
		count_after = store ? held_count_q + 2'd1 : held_count_q;
		h0 = (store && held_count_q == 2'd0) ? sx.val : held_q[0];
		h1 = (store && held_count_q == 2'd1) ? sx.val : held_q[1];
		h2 = (store && held_count_q == 2'd2) ? sx.val : held_q[2];

		job_word = '0;
		job_word.fin = char_word.final_char;
		if (complete) begin
			job_word.bytes[0] = {held_q[0], held_q[1][5:4]};
			job_word.bytes[1] = {held_q[1][3:0], held_q[2][5:2]};
			job_word.bytes[2] = {held_q[2][1:0], sx.val};
			job_word.nb = 2'd3;
		end else if (count_after == 2'd3) begin
			job_word.bytes[0] = {h0, h1[5:4]};
			job_word.bytes[1] = {h1[3:0], h2[5:2]};
			job_word.nb = 2'd2;
		end else if (count_after == 2'd2) begin
			job_word.bytes[0] = {h0, h1[5:4]};
			job_word.nb = 2'd1;
		end
		job_push = accept && (complete || char_word.final_char);
	end

	always_ff @(posedge clk) begin
		if (accept && store) begin
			held_q[held_count_q] <= sx.val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count_q <= '0;
		end else if (accept) begin
			if (char_word.final_char || complete) begin
				held_count_q <= '0;
			end else begin
				held_count_q <= count_after;
			end
		end
	end

endmodule

// ----- design/b64d_queue.sv -----
module b64d_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  b64d_pkg::job_t push_data,
	input  logic           pop,
	output b64d_pkg::job_t pop_data,
	output logic           full,
	output logic           empty
);
	import b64d_pkg::*;

	job_t                   mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_PTR_W:0]   count_q;

	assign full = (count_q == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- design/b64d_back.sv -----
module b64d_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  b64d_pkg::job_t         job_word,
	input  logic                   queue_empty,
	output logic                   job_pop,
	output logic                   result_valid,
	input  logic                   result_ready,
	output b64d_pkg::result_word_t result_word
);
	import b64d_pkg::*;

	logic [1:0]   idx_q;
	logic         valid_q;
	result_word_t word_q;
	result_word_t next_word;
	logic         load;
	logic         last;

	assign result_valid = valid_q;
	assign result_word = word_q;
	assign load = !valid_q || result_ready;

	always_comb begin
		last = (job_word.nb == 2'd0) || (idx_q == job_word.nb - 2'd1);
		next_word.byte_out = job_word.bytes[idx_q];
		next_word.byte_valid = (job_word.nb != 2'd0);
		next_word.run_last = last;
		next_word.stream_end = last && job_word.fin;
		job_pop = load && !queue_empty && last;
	end

	always_ff @(posedge clk) begin
		if (load && !queue_empty) begin
			word_q <= next_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q <= '0;
		end else if (load) begin
			valid_q <= !queue_empty;
			if (!queue_empty) begin
				idx_q <= last ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

endmodule

// ----- dv/tb_base64_stream_decoder.sv -----
module tb_base64_stream_decoder;
	timeunit 1ns;
	timeprecision 1ps;

	import b64d_pkg::*;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_PATTERN,
		RX_SPARSE
	} rx_mode_t;

	localparam int RANDOM_CHARS = 500;
	localparam int PRESSURE_AT = 100;
	localparam int PRESSURE_CYCLES = 300;
	localparam int DRAIN_LIMIT = 5000;
	localparam string ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
	localparam string BLANKS = " \t\r\n";

	logic         clk;
	logic         arst_n;
	logic         char_valid;
	logic         char_ready;
	char_word_t   char_word;
	logic         result_valid;
	logic         result_ready;
	result_word_t result_word;

	char_word_t   text_chars[$];
	result_word_t awaited_results[$];

	logic [5:0] held_sextets[3];
	int         held_count;

	bit       char_taken;
	int       burst_left;
	int       gap_left;
	int       hold_left;
	bit       pressure_done;
	rx_mode_t rx_mode;
	int       mode_left;
	logic [7:0] stall_pattern;

	int chars_queued;
	int chars_accepted;
	int texts_built;
	int bytes_checked;
	int end_markers;
	int errors;

	base64_stream_decoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_valid   (char_valid),
		.char_ready   (char_ready),
		.char_word    (char_word),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_word  (result_word)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic push_char(input logic [7:0] c, input logic fin);
		char_word_t w;
		w.char_code = c;
		w.final_char = fin;
		text_chars.push_back(w);
		chars_queued++;
	endtask

	task automatic alphabet_value(input logic [7:0] c, output bit hit, output logic [5:0] v);
		hit = 1'b1;
		v = '0;
		if (c >= "A" && c <= "Z") begin
			v = 6'(c - "A");
		end else if (c >= "a" && c <= "z") begin
			v = 6'(c - "a") + LOWER_BASE;
		end else if (c >= "0" && c <= "9") begin
			v = 6'(c - "0") + DIGIT_BASE;
		end else if (c == "+") begin
			v = PLUS_CODE;
		end else if (c == "/") begin
			v = SLASH_CODE;
		end else begin
			hit = 1'b0;
		end
	endtask

	task automatic decode_char(input char_word_t w);
		bit           hit;
		logic [5:0]   v;
		logic [7:0]   out_bytes[$];
		result_word_t r;
		alphabet_value(w.char_code, hit, v);
		if (hit) begin
			if (held_count == 3) begin
				out_bytes.push_back({held_sextets[0], held_sextets[1][5:4]});
				out_bytes.push_back({held_sextets[1][3:0], held_sextets[2][5:2]});
				out_bytes.push_back({held_sextets[2][1:0], v});
				held_count = 0;
			end else begin
				held_sextets[held_count] = v;
				held_count++;
			end
		end
		if (w.final_char && out_bytes.size() == 0 && held_count >= 2) begin
			out_bytes.push_back({held_sextets[0], held_sextets[1][5:4]});
			if (held_count == 3)
				out_bytes.push_back({held_sextets[1][3:0], held_sextets[2][5:2]});
		end
		if (w.final_char)
			held_count = 0;
		foreach (out_bytes[i]) begin
			r.byte_out = out_bytes[i];
			r.byte_valid = 1'b1;
			r.run_last = (i == out_bytes.size() - 1);
			r.stream_end = r.run_last && w.final_char;
			awaited_results.push_back(r);
		end
		if (w.final_char && out_bytes.size() == 0) begin
			r.byte_out = 8'h00;
			r.byte_valid = 1'b0;
			r.run_last = 1'b1;
			r.stream_end = 1'b1;
			awaited_results.push_back(r);
		end
	endtask

	task automatic check_result(input result_word_t got);
		result_word_t want;
		if (awaited_results.size() == 0) begin
			$error("result word %p arrived with none awaited", got);
			errors++;
		end else begin
			want = awaited_results.pop_front();
			if (got.byte_out !== want.byte_out) begin
				$error("byte_out: expected %0h, got %0h", want.byte_out, got.byte_out);
				errors++;
			end
			if (got.byte_valid !== want.byte_valid) begin
				$error("byte_valid: expected %0b, got %0b", want.byte_valid, got.byte_valid);
				errors++;
			end
			if (got.run_last !== want.run_last) begin
				$error("run_last: expected %0b, got %0b", want.run_last, got.run_last);
				errors++;
			end
			if (got.stream_end !== want.stream_end) begin
				$error("stream_end: expected %0b, got %0b", want.stream_end, got.stream_end);
				errors++;
			end
			if (want.byte_valid)
				bytes_checked++;
			if (want.stream_end)
				end_markers++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (char_valid && char_ready) begin
				decode_char(char_word);
				char_taken = 1'b1;
				chars_accepted++;
			end
			if (result_valid && result_ready)
				check_result(result_word);
		end
	end

	// hold the word until taken, otherwise advance through bursts and gaps
	always @(negedge clk) begin
		if (arst_n && !(char_valid && !char_taken)) begin
			char_taken = 1'b0;
			if (gap_left > 0) begin
				char_valid <= 1'b0;
				gap_left--;
			end else if (text_chars.size() > 0) begin
				char_word <= text_chars.pop_front();
				char_valid <= 1'b1;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
				end
			end else begin
				char_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (!pressure_done && chars_accepted >= PRESSURE_AT) begin
				hold_left = PRESSURE_CYCLES;
				pressure_done = 1'b1;
			end
			if (mode_left <= 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(16, 96);
				stall_pattern = 8'($urandom) | 8'h01;
			end else begin
				mode_left--;
			end
			if (hold_left > 0) begin
				result_ready <= 1'b0;
				hold_left--;
			end else begin
				case (rx_mode)
					RX_OPEN: result_ready <= 1'b1;
					RX_COIN: result_ready <= 1'($urandom_range(0, 1));
					RX_PATTERN: begin
						result_ready <= stall_pattern[0];
						stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
					end
					default: result_ready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	initial begin
		#2ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : stimulus
		logic [7:0] text[$];
		int         random_start;
		int         groups;
		int         tail;
		int         drain;

		arst_n = 1'b0;
		char_valid = 1'b0;
		char_word = '0;
		result_ready = 1'b0;
		char_taken = 1'b0;
		burst_left = 8;
		gap_left = 0;
		hold_left = 0;
		pressure_done = 1'b0;
		mode_left = 0;
		rx_mode = RX_OPEN;
		stall_pattern = 8'hFF;
		held_count = 0;

		// full group with skipped extremes in between
		push_char("A", 1'b0);
		push_char(8'h00, 1'b0);
		push_char("z", 1'b0);
		push_char("0", 1'b0);
		push_char(8'hFF, 1'b0);
		push_char("9", 1'b0);
		push_char("+", 1'b0);
		push_char("/", 1'b0);
		push_char("Z", 1'b0);
		push_char("a", 1'b0);
		// two held, final padding: one byte
		push_char("T", 1'b0);
		push_char("W", 1'b0);
		push_char("=", 1'b1);
		// final completes a group
		push_char("T", 1'b0);
		push_char("W", 1'b0);
		push_char("F", 1'b0);
		push_char("u", 1'b1);
		// three held, final padding: two bytes
		push_char("T", 1'b0);
		push_char("W", 1'b0);
		push_char("E", 1'b0);
		push_char("=", 1'b1);
		// lone sextet dropped
		push_char("Q", 1'b0);
		push_char(" ", 1'b1);
		// final with nothing held
		push_char(8'hFF, 1'b1);
		// final sextet makes three held
		push_char("T", 1'b0);
		push_char("W", 1'b0);
		push_char("F", 1'b1);
		texts_built = 7;

		random_start = chars_queued;
		while (chars_queued - random_start < RANDOM_CHARS) begin
			if ($urandom_range(0, 9) < 8) begin
				groups = $urandom_range(0, 4);
				tail = $urandom_range(0, 3);
				text.delete();
				repeat (groups * 4 + tail)
					text.push_back(ALPHABET[$urandom_range(0, 63)]);
				if ($urandom_range(0, 3) != 0) begin
					if (tail == 2) begin
						text.push_back("=");
						text.push_back("=");
					end else if (tail == 3) begin
						text.push_back("=");
					end
				end
				if (text.size() == 0)
					text.push_back("=");
				foreach (text[i]) begin
					if ($urandom_range(0, 11) == 0)
						push_char(BLANKS[$urandom_range(0, 3)], 1'b0);
					push_char(text[i], i == text.size() - 1);
				end
				texts_built++;
			end else begin
				repeat ($urandom_range(1, 8))
					push_char(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
			end
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (text_chars.size() != 0 || char_valid)
			@(posedge clk);
		drain = 0;
		while (awaited_results.size() != 0 && drain < DRAIN_LIMIT) begin
			@(posedge clk);
			drain++;
		end
		repeat (8) @(posedge clk);
		if (awaited_results.size() != 0) begin
			$error("%0d result words never arrived", awaited_results.size());
			errors++;
		end

		$display("Decoded %0d characters in about %0d texts plus noise: %0d bytes and %0d end markers checked.",
			chars_accepted, texts_built, bytes_checked, end_markers);
		$display("Input held off by a %0d-cycle output stall after %0d characters.",
			PRESSURE_CYCLES, PRESSURE_AT);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- sim.f -----
design/b64d_pkg.sv
design/b64d_front.sv
design/b64d_queue.sv
design/b64d_back.sv
design/base64_stream_decoder.sv
dv/tb_base64_stream_decoder.sv
